FILE: hw/rtl/gle_pkg.sv
// Shared types, constants and helper functions for the gray tone-table scanline expander.
`default_nettype none

package gle_pkg;

	localparam int DataW        = 8;
	localparam int ModeW        = 2;
	localparam int RowWidthW    = 13;
	localparam int ApbDataW     = 32;
	localparam int ApbAddrW     = 3;
	localparam int ByteIdxW     = 4;
	localparam int MaxWidthDflt = 4096;

	localparam logic [DataW-1:0] FillByte   = 8'hFF;
	localparam logic [DataW-1:0] FilterNone = 8'h00;

	// input opcodes
	localparam logic OP_PIXEL       = 1'b0;
	localparam logic OP_TABLE_WRITE = 1'b1;

	// register index, taken from paddr[2]
	localparam logic REG_OUTPUT_MODE = 1'b0;
	localparam logic REG_ROW_WIDTH   = 1'b1;

	typedef enum logic [ModeW-1:0] {
		MODE_GRAY8  = 2'd0,
		MODE_GRAY16 = 2'd1,
		MODE_RGBA8  = 2'd2,
		MODE_RGBA16 = 2'd3
	} gle_mode_t;

	// per-pixel control handed from the front end to the byte emitter
	typedef struct packed {
		gle_mode_t mode;
		logic      filt;
		logic      ends;
	} gle_pix_t;

	// bytes per pixel in a mode
	function automatic logic [ByteIdxW-1:0] px_bytes(input gle_mode_t mode);
		logic [ByteIdxW-1:0] n;
		unique case (mode)
			MODE_GRAY8:  n = 4'd1;
			MODE_GRAY16: n = 4'd2;
			MODE_RGBA8:  n = 4'd4;
			MODE_RGBA16: n = 4'd8;
			default:     n = 4'd1;
		endcase
		return n;
	endfunction

	// trailing alpha bytes (0xFF) per pixel in a mode
	function automatic logic [ByteIdxW-1:0] pad_bytes(input gle_mode_t mode);
		logic [ByteIdxW-1:0] n;
		unique case (mode)
			MODE_GRAY8:  n = 4'd0;
			MODE_GRAY16: n = 4'd0;
			MODE_RGBA8:  n = 4'd1;
			MODE_RGBA16: n = 4'd2;
			default:     n = 4'd0;
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/gle_tone_ram.sv
// 256 x 8 tone table, one write port, one registered read port.
`default_nettype none

module gle_tone_ram (
	input  wire logic                        clk,
	input  wire logic                        we,
	input  wire logic [gle_pkg::DataW-1:0]   waddr,
	input  wire logic [gle_pkg::DataW-1:0]   wdata,
	input  wire logic                        re,
	input  wire logic [gle_pkg::DataW-1:0]   raddr,
	output      logic [gle_pkg::DataW-1:0]   rdata
);

	localparam int Depth = 1 << gle_pkg::DataW;

	logic [gle_pkg::DataW-1:0] mem [Depth];
	logic [gle_pkg::DataW-1:0] rd_data_s1;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rd_data_s1 <= mem[raddr];
		end
	end

	assign rdata = rd_data_s1;

endmodule

`default_nettype wire

FILE: hw/rtl/gle_byte_emitter.sv
// Lookup-result stage and byte serializer producing the raw scanline words.
`default_nettype none

module gle_byte_emitter (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        load,
	input  wire gle_pkg::gle_pix_t           pix,
	input  wire logic [gle_pkg::DataW-1:0]   rdata,
	output      logic                        busy,
	output      logic                        byte_valid,
	input  wire logic                        byte_stall,
	output      logic [gle_pkg::DataW-1:0]   out_byte,
	output      logic                        is_filter_byte,
	output      logic                        row_end,
	output      logic                        last_of_run
);

	// stage 1: table read in flight / result waiting
	logic              valid_s1;
	gle_pkg::gle_pix_t pix_s1;

	// current pixel being serialized
	logic                          cur_valid_q;
	logic [gle_pkg::DataW-1:0]     v_q;
	logic [gle_pkg::ByteIdxW-1:0]  idx_q;
	logic [gle_pkg::ByteIdxW-1:0]  last_idx_q;
	logic [gle_pkg::ByteIdxW-1:0]  ff_start_q;
	logic                          filt_q;
	logic                          ends_q;

	logic                          cur_last;
	logic                          s1_move;
	logic [gle_pkg::ByteIdxW-1:0]  n_px;
	logic [gle_pkg::ByteIdxW-1:0]  n_pad;
	logic [gle_pkg::ByteIdxW-1:0]  n_filt;

	assign cur_last = (idx_q == last_idx_q);
	assign s1_move  = valid_s1 && (!cur_valid_q || (cur_last && !byte_stall));
	assign busy     = valid_s1 && !s1_move;

	assign n_px   = gle_pkg::px_bytes(pix_s1.mode);
	assign n_pad  = gle_pkg::pad_bytes(pix_s1.mode);
	assign n_filt = {{(gle_pkg::ByteIdxW-1){1'b0}}, pix_s1.filt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pix_s1 <= pix;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (s1_move) begin
			cur_valid_q <= 1'b1;
			idx_q       <= '0;
		end else if (cur_valid_q && !byte_stall) begin
			if (cur_last) begin
				cur_valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			v_q        <= rdata;
			filt_q     <= pix_s1.filt;
			ends_q     <= pix_s1.ends;
			last_idx_q <= n_filt + n_px - 1'b1;
			// past the last index in gray modes, so no fill byte appears
			ff_start_q <= n_filt + n_px - n_pad;
		end
	end

	always_comb begin
		byte_valid     = cur_valid_q;
		is_filter_byte = filt_q && (idx_q == '0);
		row_end        = cur_last && ends_q;
		last_of_run    = cur_last;
		priority if (is_filter_byte) begin
			out_byte = gle_pkg::FilterNone;
		end else if (idx_q >= ff_start_q) begin
			out_byte = gle_pkg::FillByte;
		end else begin
			out_byte = v_q;
		end
	end

	// a pixel still owing bytes does not vanish
	a_hold_cur: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q && !cur_last |=> cur_valid_q)
		else $error("emitter dropped a pixel mid-run");

	// index never runs past the pixel's last byte
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> idx_q <= last_idx_q)
		else $error("byte index beyond run length");

	// a waiting lookup result keeps its control until it moves on
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_move |=> valid_s1 && $stable(pix_s1))
		else $error("stage 1 changed while blocked");

	// the filter byte never closes a run
	a_filt_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q && is_filter_byte |-> !last_of_run && !row_end)
		else $error("filter byte flagged as run end");

endmodule

`default_nettype wire

FILE: hw/rtl/gray_lut_png_scanline_expander.sv
// Top level: gray samples through a tone table into raw PNG scanline bytes.
//
//  channel    dir  handshake               payload
//  ---------  ---  ----------------------  ----------------------------------------------
//  pix        in   pix_valid / pix_stall   opcode, gray_sample, table_index, table_value
//  byte       out  byte_valid / byte_stall out_byte, is_filter_byte, row_end, last_of_run
//  apb        in   psel/penable/pready     paddr, pwrite, pwdata, prdata
//
//  A table write sends no word. A pixel sends 1..9 words, one word a cycle while
//  byte_stall is low, so its rate is set by the byte-wide output register. The
//  table read is registered and overlaps the previous pixel's serialization.
//  Reset clears the column count and all valid flags and resets the registers;
//  the table itself is not cleared. byte_stall holds the current word and, once
//  the lookup stage is full, asserts pix_stall.
`default_nettype none

module gray_lut_png_scanline_expander #(
	parameter int MAX_WIDTH = gle_pkg::MaxWidthDflt
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// configuration
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [gle_pkg::ApbAddrW-1:0]   paddr,
	input  wire logic [gle_pkg::ApbDataW-1:0]   pwdata,
	output      logic [gle_pkg::ApbDataW-1:0]   prdata,
	output      logic                           pready,
	// input words
	input  wire logic                           pix_valid,
	output      logic                           pix_stall,
	input  wire logic                           opcode,
	input  wire logic [gle_pkg::DataW-1:0]      gray_sample,
	input  wire logic [gle_pkg::DataW-1:0]      table_index,
	input  wire logic [gle_pkg::DataW-1:0]      table_value,
	// output words
	output      logic                           byte_valid,
	input  wire logic                           byte_stall,
	output      logic [gle_pkg::DataW-1:0]      out_byte,
	output      logic                           is_filter_byte,
	output      logic                           row_end,
	output      logic                           last_of_run
);

	// column counter holds 0..MAX_WIDTH-1
	localparam int ColW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int MaxW  = $clog2(MAX_WIDTH + 1);
	localparam int CmpW  = ((MaxW > gle_pkg::RowWidthW) ? MaxW : gle_pkg::RowWidthW) + 1;

	gle_pkg::gle_mode_t                 mode_q;
	logic [gle_pkg::RowWidthW-1:0]      row_width_q;
	logic [ColW-1:0]                    col_q;

	logic                               cfg_wr;
	logic                               accept;
	logic                               pix_acc;
	logic                               tbl_acc;
	logic                               busy;
	logic [CmpW-1:0]                    w_eff;
	logic [CmpW-1:0]                    rw_ext;
	logic [CmpW-1:0]                    col_next;
	logic                               ends;
	gle_pkg::gle_pix_t                  pix;
	logic [gle_pkg::DataW-1:0]          rdata;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= gle_pkg::MODE_GRAY8;
			row_width_q <= gle_pkg::RowWidthW'(1);
		end else if (cfg_wr) begin
			unique case (paddr[2])
				gle_pkg::REG_OUTPUT_MODE: begin
					mode_q <= gle_pkg::gle_mode_t'(pwdata[gle_pkg::ModeW-1:0]);
				end
				gle_pkg::REG_ROW_WIDTH: begin
					row_width_q <= pwdata[gle_pkg::RowWidthW-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			gle_pkg::REG_OUTPUT_MODE: prdata = gle_pkg::ApbDataW'(mode_q);
			gle_pkg::REG_ROW_WIDTH:   prdata = gle_pkg::ApbDataW'(row_width_q);
			default:                  prdata = '0;
		endcase
	end

	// ---------------- input acceptance ----------------
	assign pix_stall = busy;
	assign accept    = pix_valid && !pix_stall;
	assign pix_acc   = accept && (opcode == gle_pkg::OP_PIXEL);
	assign tbl_acc   = accept && (opcode == gle_pkg::OP_TABLE_WRITE);

	// ---------------- row position ----------------
	// zero width acts as one, anything over MAX_WIDTH saturates
	assign rw_ext = CmpW'(row_width_q);
	always_comb begin
		priority if (row_width_q == '0) begin
			w_eff = CmpW'(1);
		end else if (rw_ext > CmpW'(MAX_WIDTH)) begin
			w_eff = CmpW'(MAX_WIDTH);
		end else begin
			w_eff = rw_ext;
		end
	end

	assign col_next = CmpW'(col_q) + 1'b1;
	assign ends     = (col_next >= w_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (pix_acc) begin
			col_q <= ends ? '0 : col_next[ColW-1:0];
		end
	end

	assign pix.mode = mode_q;
	assign pix.filt = (col_q == '0);
	assign pix.ends = ends;

	// ---------------- tone table ----------------
	gle_tone_ram u_ram (
		.clk   (clk),
		.we    (tbl_acc),
		.waddr (table_index),
		.wdata (table_value),
		.re    (pix_acc),
		.raddr (gray_sample),
		.rdata (rdata)
	);

	// ---------------- byte serializer ----------------
	gle_byte_emitter u_emit (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (pix_acc),
		.pix            (pix),
		.rdata          (rdata),
		.busy           (busy),
		.byte_valid     (byte_valid),
		.byte_stall     (byte_stall),
		.out_byte       (out_byte),
		.is_filter_byte (is_filter_byte),
		.row_end        (row_end),
		.last_of_run    (last_of_run)
	);

	// column count stays inside the saturated row width range
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		CmpW'(col_q) < CmpW'(MAX_WIDTH))
		else $error("column count out of range");

	// a row-ending pixel restarts the column count
	a_col_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		pix_acc && ends |=> col_q == '0)
		else $error("column count did not wrap at row end");

	// table writes leave the row position alone
	a_tbl_col: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_acc |=> $stable(col_q))
		else $error("table write moved the column count");

endmodule

`default_nettype wire
